// ===== rtl/bhc_pkg.sv =====
// ----------------------------------------------------------------------------
// bhc_pkg: shared types and constants for the byte histogram counter
// Counter width, bin geometry, byte class bounds and controller commands.
// ----------------------------------------------------------------------------
package bhc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int OUT_W       = 32;
  localparam int NUM_BINS    = 256;
  localparam int BIN_IDX_W   = $clog2(NUM_BINS);

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [OUT_W-1:0]       out_word_t;
  typedef logic [BIN_IDX_W-1:0]   bin_idx_t;

  localparam count_t CNT_MAX = '1;

  // item commands
  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // byte class bounds
  localparam bin_idx_t PRINT_LO  = 8'd32;
  localparam bin_idx_t PRINT_HI  = 8'd126;
  localparam bin_idx_t CTRL_LO   = 8'd1;
  localparam bin_idx_t CTRL_MID  = 8'd8;
  localparam bin_idx_t CTRL_FF   = 8'd12;
  localparam bin_idx_t CTRL_HLO  = 8'd14;
  localparam bin_idx_t CTRL_HHI  = 8'd31;
  localparam bin_idx_t HIGH_LO   = 8'd128;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the item and start the bin read
    logic commit;   // update counters and load the result register
  } ctl_t;

  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == CNT_MAX) ? v : v + count_t'(1);
  endfunction

  function automatic out_word_t to_out(input count_t v);
    to_out = OUT_W'(v);
  endfunction

endpackage

// ===== rtl/bhc_in_if.sv =====
// ----------------------------------------------------------------------------
// bhc_in_if: input item channel
// Valid/ready channel carrying a command bit and a byte.
// ----------------------------------------------------------------------------
interface bhc_in_if;
  logic                valid;
  logic                ready;
  logic                cmd;
  bhc_pkg::bin_idx_t   byte_value;

  modport source (output valid, output cmd, output byte_value, input ready);
  modport sink   (input valid, input cmd, input byte_value, output ready);
endinterface

// ===== rtl/bhc_out_if.sv =====
// ----------------------------------------------------------------------------
// bhc_out_if: result channel
// Valid/ready channel carrying the addressed bin and the four class totals.
// ----------------------------------------------------------------------------
interface bhc_out_if;
  logic                 valid;
  logic                 ready;
  bhc_pkg::out_word_t   bin_count;
  bhc_pkg::out_word_t   printable_total;
  bhc_pkg::out_word_t   control_other_total;
  bhc_pkg::out_word_t   high_total;
  bhc_pkg::out_word_t   grand_total;

  modport source (output valid, output bin_count, output printable_total,
                  output control_other_total, output high_total,
                  output grand_total, input ready);
  modport sink   (input valid, input bin_count, input printable_total,
                  input control_other_total, input high_total,
                  input grand_total, output ready);
endinterface

// ===== rtl/bhc_ram.sv =====
// ----------------------------------------------------------------------------
// bhc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bhc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bhc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bhc_ctrl: item sequencer
// Two-state controller: accept an item, then commit it once the result
// register is free. Owns the result valid flag.
// ----------------------------------------------------------------------------
module bhc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output bhc_pkg::ctl_t ctl
);

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    in_ready    = (state_r == S_IDLE);
    ctl.capture = in_valid && in_ready;
    // commit only when the result slot is empty or draining this cycle
    ctl.commit  = (state_r == S_LOOKUP) && (!out_valid_r || out_ready);

    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (ctl.capture) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (ctl.commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_capture_then_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.capture |=> state_r == S_LOOKUP)
    else $error("accepted item did not enter lookup");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> out_valid_r)
    else $error("commit did not present a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> !out_valid_r || out_ready)
    else $error("commit overwrote an untaken result");

  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.capture && ctl.commit))
    else $error("capture and commit in the same cycle");
`endif

endmodule

// ===== rtl/bhc_dpath.sv =====
// ----------------------------------------------------------------------------
// bhc_dpath: histogram datapath
// Bin store with per-bin valid bits, saturating class totals and the
// result register.
// ----------------------------------------------------------------------------
module bhc_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  bhc_pkg::ctl_t       ctl,
  input  logic                in_cmd,
  input  bhc_pkg::bin_idx_t   in_byte,
  output bhc_pkg::out_word_t  bin_count,
  output bhc_pkg::out_word_t  printable_total,
  output bhc_pkg::out_word_t  control_other_total,
  output bhc_pkg::out_word_t  high_total,
  output bhc_pkg::out_word_t  grand_total
);

  logic                      cmd_r;
  bhc_pkg::bin_idx_t         idx_r;
  logic [bhc_pkg::NUM_BINS-1:0] bin_vld_r;
  bhc_pkg::count_t           print_sum_r;
  bhc_pkg::count_t           ctrl_sum_r;
  bhc_pkg::count_t           high_sum_r;
  bhc_pkg::count_t           all_sum_r;
  bhc_pkg::out_word_t        bin_out_r;
  bhc_pkg::out_word_t        print_out_r;
  bhc_pkg::out_word_t        ctrl_out_r;
  bhc_pkg::out_word_t        high_out_r;
  bhc_pkg::out_word_t        all_out_r;

  bhc_pkg::count_t ram_rdata;
  bhc_pkg::count_t bin_cur;
  bhc_pkg::count_t bin_nxt;
  bhc_pkg::count_t print_sum_nxt;
  bhc_pkg::count_t ctrl_sum_nxt;
  bhc_pkg::count_t high_sum_nxt;
  bhc_pkg::count_t all_sum_nxt;
  logic            do_count;
  logic            is_print;
  logic            is_ctrl;
  logic            is_high;
  logic            bin_we;

  bhc_ram #(
    .WIDTH (bhc_pkg::COUNT_WIDTH),
    .DEPTH (bhc_pkg::NUM_BINS)
  ) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (idx_r),
    .wdata (bin_nxt),
    .re    (ctl.capture),
    .raddr (in_byte),
    .rdata (ram_rdata)
  );

  always_comb begin
    is_print = (idx_r >= bhc_pkg::PRINT_LO) && (idx_r <= bhc_pkg::PRINT_HI);
    is_ctrl  = ((idx_r >= bhc_pkg::CTRL_LO) && (idx_r <= bhc_pkg::CTRL_MID)) ||
               (idx_r == bhc_pkg::CTRL_FF) ||
               ((idx_r >= bhc_pkg::CTRL_HLO) && (idx_r <= bhc_pkg::CTRL_HHI));
    is_high  = (idx_r >= bhc_pkg::HIGH_LO);
    do_count = (cmd_r == bhc_pkg::CMD_COUNT);
    bin_we   = ctl.commit && do_count;

    // a bin never written since reset reads as zero
    bin_cur       = bin_vld_r[idx_r] ? ram_rdata : '0;
    bin_nxt       = do_count ? bhc_pkg::sat_inc(bin_cur) : bin_cur;
    print_sum_nxt = (do_count && is_print) ? bhc_pkg::sat_inc(print_sum_r) : print_sum_r;
    ctrl_sum_nxt  = (do_count && is_ctrl)  ? bhc_pkg::sat_inc(ctrl_sum_r)  : ctrl_sum_r;
    high_sum_nxt  = (do_count && is_high)  ? bhc_pkg::sat_inc(high_sum_r)  : high_sum_r;
    all_sum_nxt   = do_count ? bhc_pkg::sat_inc(all_sum_r) : all_sum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_vld_r   <= '0;
      print_sum_r <= '0;
      ctrl_sum_r  <= '0;
      high_sum_r  <= '0;
      all_sum_r   <= '0;
    end else if (ctl.commit) begin
      if (do_count) begin
        bin_vld_r[idx_r] <= 1'b1;
      end
      print_sum_r <= print_sum_nxt;
      ctrl_sum_r  <= ctrl_sum_nxt;
      high_sum_r  <= high_sum_nxt;
      all_sum_r   <= all_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= in_cmd;
      idx_r <= in_byte;
    end
    if (ctl.commit) begin
      bin_out_r   <= bhc_pkg::to_out(bin_nxt);
      print_out_r <= bhc_pkg::to_out(print_sum_nxt);
      ctrl_out_r  <= bhc_pkg::to_out(ctrl_sum_nxt);
      high_out_r  <= bhc_pkg::to_out(high_sum_nxt);
      all_out_r   <= bhc_pkg::to_out(all_sum_nxt);
    end
  end

  assign bin_count           = bin_out_r;
  assign printable_total     = print_out_r;
  assign control_other_total = ctrl_out_r;
  assign high_total          = high_out_r;
  assign grand_total         = all_out_r;

`ifndef SYNTH
  a_count_marks_bin: assert property (@(posedge clk) disable iff (!rst_n)
    bin_we |=> bin_vld_r[$past(idx_r)])
    else $error("counted bin not marked valid");

  a_read_holds_total: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit && !do_count |=> $stable(all_sum_r))
    else $error("read item changed the grand total");
`endif

endmodule

// ===== rtl/byte_histogram_counter_core.sv =====
// ----------------------------------------------------------------------------
// byte_histogram_counter_core: 256-bin byte histogram with class totals
// Top level joining the sequencer and the histogram datapath.
// ----------------------------------------------------------------------------
// Input channel (in_chan): cmd selects count (0) or read (1) of the bin
// addressed by byte_value. Result channel (out_chan): the addressed bin
// after the item plus the printable, other-control, high and grand totals.
// Every accepted item yields exactly one result; all counters saturate.
//
// Timing: an item is accepted in the idle state and the bin store is read on
// that edge; in the lookup state, once the result slot is free, the counters
// are updated and the result register loaded, raising out_chan.valid.
// A new item is accepted only after the previous one has committed, as the
// registered read of the bin store is followed by its write-back.
// A finished result waits in the output register; the next item is still
// accepted, and its commit stalls only while the previous result is untaken.
// Reset (synchronous, active low) clears the per-bin valid flags, so every
// bin reads as zero at once; the totals and the result flag are cleared
// too. No clearing pass is needed.
// ----------------------------------------------------------------------------
module byte_histogram_counter_core (
  input  logic      clk,
  input  logic      rst_n,
  bhc_in_if.sink    in_chan,
  bhc_out_if.source out_chan
);

  bhc_pkg::ctl_t ctl;
  logic          in_ready;
  logic          out_valid;

  bhc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .ctl       (ctl)
  );

  bhc_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .in_cmd              (in_chan.cmd),
    .in_byte             (in_chan.byte_value),
    .bin_count           (out_chan.bin_count),
    .printable_total     (out_chan.printable_total),
    .control_other_total (out_chan.control_other_total),
    .high_total          (out_chan.high_total),
    .grand_total         (out_chan.grand_total)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

endmodule
